>>> rtl/id_dk_pkg.sv
// ----------------------------------------------------------------------------
// id_dk_pkg
// shared types and constants of the identity number date key extractor
// ----------------------------------------------------------------------------
package id_dk_pkg;

    localparam int WIN_LEN   = 17;
    localparam int DIGIT_W   = 4;
    localparam int RUN_W     = $clog2(WIN_LEN + 1);
    localparam int CH_W      = 8;
    localparam int REGION_W  = 20;
    localparam int KEY_W     = 32;
    localparam int SEQ_SH    = 16;

    // character codes
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CH_X_LOW = 8'h78;

    // reciprocal constants for division by 100 and by 5
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [13:0] RECIP_5      = 14'd13108;
    localparam int          RECIP_5_SH   = 16;

    // 306 from the day formula plus the day number of 1900-01-01
    localparam logic [KEY_W-1:0] EPOCH_OFS = 32'd693902;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [WIN_LEN-1:0][DIGIT_W-1:0] t_window;

    // word handed from the digit row to the date pipeline
    typedef struct packed {
        logic    found;
        t_window digits;
    } t_tok;

endpackage

>>> rtl/id_dk_cell.sv
// ----------------------------------------------------------------------------
// id_dk_cell
// one digit cell of the shifting window row
// ----------------------------------------------------------------------------
module id_dk_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_shift,
    input  id_dk_pkg::t_digit i_digit,
    output id_dk_pkg::t_digit o_digit
);
    import id_dk_pkg::*;

    t_digit r_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_digit <= '0;
        end else if (i_shift) begin
            r_digit <= i_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

>>> rtl/id_dk_calc.sv
// ----------------------------------------------------------------------------
// id_dk_calc
// five stage pipeline from a matched digit window to region and day key
// ----------------------------------------------------------------------------
module id_dk_calc (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  id_dk_pkg::t_tok                  i_tok,
    output logic                             o_valid,
    output logic                             o_status,
    output logic [id_dk_pkg::REGION_W-1:0]   o_region_code,
    output logic [id_dk_pkg::KEY_W-1:0]      o_day_key
);
    import id_dk_pkg::*;

    t_window d;

    // stage 1: decimal to binary
    logic                r_v1, r_found1;
    logic [REGION_W-1:0] r_region1, n_region1;
    logic [13:0]         r_year1, n_year1;
    logic [6:0]          r_month1, n_month1, r_day1, n_day1;
    logic [9:0]          r_seq1, n_seq1;

    // stage 2: month shift and month term
    logic                r_v2, r_found2;
    logic [REGION_W-1:0] r_region2;
    logic signed [14:0]  r_ya2, n_ya2;
    logic [13:0]         r_t1_2, n_t1_2;
    logic [6:0]          r_day2, n_ma2;
    logic [9:0]          r_seq2;
    logic                n_early;

    // stage 3: reciprocal products
    logic                r_v3, r_found3;
    logic [REGION_W-1:0] r_region3;
    logic signed [31:0]  r_y365, n_y365;
    logic [11:0]         r_y4, n_y4, r_q5, n_q5, n_yq;
    logic [6:0]          r_q100, n_q100, r_q400, n_q400, r_day3;
    logic [9:0]          r_seq3;
    logic [13:0]         n_yp;
    logic [26:0]         n_p100;
    logic [24:0]         n_p400;
    logic [27:0]         n_p5;

    // stage 4: partial sums
    logic                r_v4, r_found4;
    logic [REGION_W-1:0] r_region4;
    logic [KEY_W-1:0]    r_a4, n_a4;
    logic [12:0]         r_b4, n_b4;
    logic [9:0]          r_seq4;

    // stage 5: output word
    logic                r_ov, r_status;
    logic [REGION_W-1:0] r_region5;
    logic [KEY_W-1:0]    r_key5, n_key5;

    always_comb begin
        d = i_tok.digits;
        n_region1 = 20'(d[0]) * 20'd100000 + 20'(d[1]) * 20'd10000
                  + 20'(d[2]) * 20'd1000 + 20'(d[3]) * 20'd100
                  + 20'(d[4]) * 20'd10 + 20'(d[5]);
        n_year1   = 14'(d[6]) * 14'd1000 + 14'(d[7]) * 14'd100
                  + 14'(d[8]) * 14'd10 + 14'(d[9]);
        n_month1  = 7'(d[10]) * 7'd10 + 7'(d[11]);
        n_day1    = 7'(d[12]) * 7'd10 + 7'(d[13]);
        n_seq1    = 10'(d[14]) * 10'd100 + 10'(d[15]) * 10'd10 + 10'(d[16]);
    end

    always_comb begin
        n_early = (r_month1 < 7'd3);
        n_ya2   = n_early ? 15'({1'b0, r_year1}) - 15'd1 : 15'({1'b0, r_year1});
        n_ma2   = n_early ? r_month1 + 7'd12 : r_month1;
        n_t1_2  = 14'(16'(n_ma2) * 16'd153 - 16'd457);
    end

    always_comb begin
        n_yp   = r_ya2[13:0];
        n_yq   = n_yp[13:2];
        n_p100 = 27'(n_yp) * 27'(RECIP_100);
        n_p400 = 25'(n_yq) * 25'(RECIP_100);
        n_p5   = 28'(r_t1_2) * 28'(RECIP_5);
        n_y365 = 32'(r_ya2) * 32'sd365;
        n_q5   = 12'(n_p5 >> RECIP_5_SH);
        // year minus one below zero: the year quotients truncate to zero
        if (r_ya2[14]) begin
            n_y4   = '0;
            n_q100 = '0;
            n_q400 = '0;
        end else begin
            n_y4   = n_yq;
            n_q100 = 7'(n_p100 >> RECIP_100_SH);
            n_q400 = 7'(n_p400 >> RECIP_100_SH);
        end
    end

    always_comb begin
        n_a4   = KEY_W'(r_y365) + KEY_W'(r_y4) - KEY_W'(r_q100) + KEY_W'(r_q400);
        n_b4   = 13'(r_q5) + 13'(r_day3);
        n_key5 = (r_a4 + KEY_W'(r_b4) - EPOCH_OFS) | (KEY_W'(r_seq4) << SEQ_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_found1  <= i_tok.found;
            r_region1 <= n_region1;
            r_year1   <= n_year1;
            r_month1  <= n_month1;
            r_day1    <= n_day1;
            r_seq1    <= n_seq1;

            r_found2  <= r_found1;
            r_region2 <= r_region1;
            r_ya2     <= n_ya2;
            r_t1_2    <= n_t1_2;
            r_day2    <= r_day1;
            r_seq2    <= r_seq1;

            r_found3  <= r_found2;
            r_region3 <= r_region2;
            r_y365    <= n_y365;
            r_y4      <= n_y4;
            r_q100    <= n_q100;
            r_q400    <= n_q400;
            r_q5      <= n_q5;
            r_day3    <= r_day2;
            r_seq3    <= r_seq2;

            r_found4  <= r_found3;
            r_region4 <= r_region3;
            r_a4      <= n_a4;
            r_b4      <= n_b4;
            r_seq4    <= r_seq3;

            r_status  <= !r_found4;
            r_region5 <= r_found4 ? r_region4 : '0;
            r_key5    <= r_found4 ? n_key5 : '0;
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_status;
    assign o_region_code = r_region5;
    assign o_day_key     = r_key5;

endmodule

>>> rtl/id_number_date_key_extract_core.sv
// ----------------------------------------------------------------------------
// id_number_date_key_extract_core
// scans a byte string for an 18 character identity number and derives a key
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle while the output side keeps up. Bytes
// slide into a row of 17 digit cells beside a run counter; the leftmost
// window of 17 digits followed by a digit, X or x freezes the row. On the
// byte flagged last one result word leaves through the date pipeline:
// status 0 with the six digit region and the day key, or status 1 with both
// zero. The pipeline stages are decimal conversion, month shift,
// reciprocal products and two adder stages. A stalled output holds the
// whole pipeline and input ready falls with it, so bytes keep flowing at
// one per cycle whenever o_valid is low or i_ready is high.
// ----------------------------------------------------------------------------
module id_number_date_key_extract_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [id_dk_pkg::CH_W-1:0]     i_ch,
    input  logic                           i_last,
    // result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_status,
    output logic [id_dk_pkg::REGION_W-1:0] o_region_code,
    output logic [id_dk_pkg::KEY_W-1:0]    o_day_key
);
    import id_dk_pkg::*;

    logic             en;          // pipeline advance
    logic             acc;         // byte accepted
    logic             is_digit;
    logic             is_tail;
    logic             run_full;
    logic             match;       // window completes on this byte
    logic             shift;       // new digit enters the row
    logic             clr;         // end of string clears the row
    logic [RUN_W-1:0] r_run, n_run;
    logic             r_found, n_found;
    t_window          window;
    t_tok             tok;

    // whole pipeline moves unless a finished word is stuck at the output
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    // character classes
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_tail  = is_digit || (i_ch == CH_X_UP) || (i_ch == CH_X_LOW);
    assign run_full = (r_run == RUN_W'(WIN_LEN));

    // a window matches only before the first match of the string
    assign match = !r_found && is_tail && run_full;
    assign shift = acc && !r_found && !match && is_digit;
    assign clr   = acc && i_last;

    // run counter saturates at the window length, frozen once found
    always_comb begin
        n_run   = r_run;
        n_found = r_found;
        if (acc) begin
            if (i_last) begin
                n_run   = '0;
                n_found = 1'b0;
            end else begin
                n_found = r_found || match;
                if (!r_found && !match) begin
                    if (!is_digit) begin
                        n_run = '0;
                    end else if (!run_full) begin
                        n_run = r_run + RUN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_found <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_found <= n_found;
        end
    end

    // row of digit cells, oldest at index 0, new digits enter at the top
    genvar gi;
    generate
        for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
            t_digit cell_in;
            if (gi == WIN_LEN - 1) begin : g_head
                assign cell_in = i_ch[DIGIT_W-1:0];
            end else begin : g_link
                assign cell_in = window[gi+1];
            end
            id_dk_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_clr   (clr),
                .i_shift (shift),
                .i_digit (cell_in),
                .o_digit (window[gi])
            );
        end
    endgenerate

    // the row is frozen after a match, so it still holds the matched digits
    assign tok.found  = r_found || match;
    assign tok.digits = window;

    id_dk_calc u_calc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (clr),
        .i_tok         (tok),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_region_code (o_region_code),
        .o_day_key     (o_day_key)
    );

endmodule

>>> rtl/id_dk_chk.sv
// ----------------------------------------------------------------------------
// id_dk_chk
// port level checks on the date key extractor, bound to the top level
// ----------------------------------------------------------------------------
module id_dk_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic [id_dk_pkg::CH_W-1:0]     i_ch,
    input logic                           i_last,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_status,
    input logic [id_dk_pkg::REGION_W-1:0] o_region_code,
    input logic [id_dk_pkg::KEY_W-1:0]    o_day_key
);
    import id_dk_pkg::*;

    // no word survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // a no match word carries zero region and key
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_region_code == '0) && (o_day_key == '0))
        else $error("no match word with non-zero payload");

    // six decimal digits never exceed 999999
    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_region_code <= 20'd999999)
        else $error("region code out of decimal range");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_region_code) && $stable(o_day_key))
        else $error("stalled output word changed");

endmodule

bind id_number_date_key_extract_core id_dk_chk u_id_dk_chk (.*);
